>>> hdl/kcat_pkg.sv
`timescale 1ns / 1ps
package kcat_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic signed [49:0] accum_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] sa;
      logic [4:0] sb;
      logic [4:0] dst;
   } kcat_op_type;

   localparam logic [2:0] K_LD  = 3'd0;
   localparam logic [2:0] K_ADD = 3'd1;
   localparam logic [2:0] K_SUB = 3'd2;
   localparam logic [2:0] K_MAC = 3'd3;
   localparam logic [2:0] K_MSC = 3'd4;
   localparam logic [2:0] K_ST  = 3'd5;
   localparam logic [2:0] K_CHK = 3'd6;
   localparam logic [2:0] K_DIV = 3'd7;

   localparam logic [4:0] SEL_POS = 5'd0;
   localparam logic [4:0] SEL_VEL = 5'd1;
   localparam logic [4:0] SEL_ACC = 5'd2;
   localparam logic [4:0] SEL_PP  = 5'd3;
   localparam logic [4:0] SEL_PV  = 5'd4;
   localparam logic [4:0] SEL_PA  = 5'd5;
   localparam logic [4:0] SEL_VV  = 5'd6;
   localparam logic [4:0] SEL_VA  = 5'd7;
   localparam logic [4:0] SEL_AA  = 5'd8;
   localparam logic [4:0] SEL_R1  = 5'd9;
   localparam logic [4:0] SEL_R2  = 5'd10;
   localparam logic [4:0] SEL_R3  = 5'd11;
   localparam logic [4:0] SEL_W2  = 5'd12;
   localparam logic [4:0] SEL_W3  = 5'd13;
   localparam logic [4:0] SEL_KP  = 5'd14;
   localparam logic [4:0] SEL_KV  = 5'd15;
   localparam logic [4:0] SEL_KA  = 5'd16;
   localparam logic [4:0] SEL_INN = 5'd17;
   localparam logic [4:0] SEL_DT  = 5'd18;
   localparam logic [4:0] SEL_H   = 5'd19;
   localparam logic [4:0] SEL_Z   = 5'd20;
   localparam logic [4:0] SEL_QP  = 5'd21;
   localparam logic [4:0] SEL_QV  = 5'd22;
   localparam logic [4:0] SEL_QA  = 5'd23;
   localparam logic [4:0] SEL_QR  = 5'd24;

   localparam logic [2:0] CSR_NOISE_POS = 3'd0;
   localparam logic [2:0] CSR_NOISE_VEL = 3'd1;
   localparam logic [2:0] CSR_NOISE_ACC = 3'd2;
   localparam logic [2:0] CSR_NOISE_MEA = 3'd3;
   localparam logic [2:0] CSR_START_X   = 3'd4;
   localparam logic [2:0] CSR_START_Y   = 3'd5;

   localparam logic [6:0] PC_UPDATE = 7'd47;
   localparam logic [6:0] PC_LAST   = 7'd79;

   function automatic kcat_op_type kcat_mk(input logic [2:0] k, input logic [4:0] a,
                                           input logic [4:0] b, input logic [4:0] d);
      kcat_op_type o;
      o.kind = k;
      o.sa   = a;
      o.sb   = b;
      o.dst  = d;
      return o;
   endfunction

   function automatic word_type kcat_sat32(input accum_type v);
      word_type r;
      if (v > 50'sh7FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -50'sh80000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Per-axis programme: prediction, then measurement update.
   function automatic kcat_op_type kcat_rom(input logic [6:0] pc);
      kcat_op_type o;
      case (pc)
         7'd0:  o = kcat_mk(K_LD,  SEL_PP,  SEL_POS, SEL_POS);
         7'd1:  o = kcat_mk(K_MAC, SEL_DT,  SEL_PV,  SEL_POS);
         7'd2:  o = kcat_mk(K_MAC, SEL_H,   SEL_PA,  SEL_POS);
         7'd3:  o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_R1);
         7'd4:  o = kcat_mk(K_LD,  SEL_PV,  SEL_POS, SEL_POS);
         7'd5:  o = kcat_mk(K_MAC, SEL_DT,  SEL_VV,  SEL_POS);
         7'd6:  o = kcat_mk(K_MAC, SEL_H,   SEL_VA,  SEL_POS);
         7'd7:  o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_R2);
         7'd8:  o = kcat_mk(K_LD,  SEL_PA,  SEL_POS, SEL_POS);
         7'd9:  o = kcat_mk(K_MAC, SEL_DT,  SEL_VA,  SEL_POS);
         7'd10: o = kcat_mk(K_MAC, SEL_H,   SEL_AA,  SEL_POS);
         7'd11: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_R3);
         7'd12: o = kcat_mk(K_LD,  SEL_VV,  SEL_POS, SEL_POS);
         7'd13: o = kcat_mk(K_MAC, SEL_DT,  SEL_VA,  SEL_POS);
         7'd14: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_W2);
         7'd15: o = kcat_mk(K_LD,  SEL_VA,  SEL_POS, SEL_POS);
         7'd16: o = kcat_mk(K_MAC, SEL_DT,  SEL_AA,  SEL_POS);
         7'd17: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_W3);
         7'd18: o = kcat_mk(K_LD,  SEL_R1,  SEL_POS, SEL_POS);
         7'd19: o = kcat_mk(K_MAC, SEL_DT,  SEL_R2,  SEL_POS);
         7'd20: o = kcat_mk(K_MAC, SEL_H,   SEL_R3,  SEL_POS);
         7'd21: o = kcat_mk(K_ADD, SEL_QP,  SEL_POS, SEL_POS);
         7'd22: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_PP);
         7'd23: o = kcat_mk(K_LD,  SEL_R2,  SEL_POS, SEL_POS);
         7'd24: o = kcat_mk(K_MAC, SEL_DT,  SEL_R3,  SEL_POS);
         7'd25: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_PV);
         7'd26: o = kcat_mk(K_LD,  SEL_R3,  SEL_POS, SEL_POS);
         7'd27: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_PA);
         7'd28: o = kcat_mk(K_LD,  SEL_W2,  SEL_POS, SEL_POS);
         7'd29: o = kcat_mk(K_MAC, SEL_DT,  SEL_W3,  SEL_POS);
         7'd30: o = kcat_mk(K_ADD, SEL_QV,  SEL_POS, SEL_POS);
         7'd31: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_VV);
         7'd32: o = kcat_mk(K_LD,  SEL_W3,  SEL_POS, SEL_POS);
         7'd33: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_VA);
         7'd34: o = kcat_mk(K_LD,  SEL_AA,  SEL_POS, SEL_POS);
         7'd35: o = kcat_mk(K_ADD, SEL_QA,  SEL_POS, SEL_POS);
         7'd36: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_AA);
         7'd37: o = kcat_mk(K_LD,  SEL_POS, SEL_POS, SEL_POS);
         7'd38: o = kcat_mk(K_MAC, SEL_VEL, SEL_DT,  SEL_POS);
         7'd39: o = kcat_mk(K_MAC, SEL_ACC, SEL_H,   SEL_POS);
         7'd40: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_POS);
         7'd41: o = kcat_mk(K_LD,  SEL_VEL, SEL_POS, SEL_POS);
         7'd42: o = kcat_mk(K_MAC, SEL_ACC, SEL_DT,  SEL_POS);
         7'd43: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_VEL);
         7'd44: o = kcat_mk(K_LD,  SEL_PP,  SEL_POS, SEL_POS);
         7'd45: o = kcat_mk(K_ADD, SEL_QR,  SEL_POS, SEL_POS);
         7'd46: o = kcat_mk(K_CHK, SEL_POS, SEL_POS, SEL_POS);
         7'd47: o = kcat_mk(K_DIV, SEL_PP,  SEL_POS, SEL_KP);
         7'd48: o = kcat_mk(K_DIV, SEL_PV,  SEL_POS, SEL_KV);
         7'd49: o = kcat_mk(K_DIV, SEL_PA,  SEL_POS, SEL_KA);
         7'd50: o = kcat_mk(K_LD,  SEL_Z,   SEL_POS, SEL_POS);
         7'd51: o = kcat_mk(K_SUB, SEL_POS, SEL_POS, SEL_POS);
         7'd52: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_INN);
         7'd53: o = kcat_mk(K_LD,  SEL_POS, SEL_POS, SEL_POS);
         7'd54: o = kcat_mk(K_MAC, SEL_KP,  SEL_INN, SEL_POS);
         7'd55: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_POS);
         7'd56: o = kcat_mk(K_LD,  SEL_VEL, SEL_POS, SEL_POS);
         7'd57: o = kcat_mk(K_MAC, SEL_KV,  SEL_INN, SEL_POS);
         7'd58: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_VEL);
         7'd59: o = kcat_mk(K_LD,  SEL_ACC, SEL_POS, SEL_POS);
         7'd60: o = kcat_mk(K_MAC, SEL_KA,  SEL_INN, SEL_POS);
         7'd61: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_ACC);
         7'd62: o = kcat_mk(K_LD,  SEL_VV,  SEL_POS, SEL_POS);
         7'd63: o = kcat_mk(K_MSC, SEL_KV,  SEL_PV,  SEL_POS);
         7'd64: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_VV);
         7'd65: o = kcat_mk(K_LD,  SEL_VA,  SEL_POS, SEL_POS);
         7'd66: o = kcat_mk(K_MSC, SEL_KV,  SEL_PA,  SEL_POS);
         7'd67: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_VA);
         7'd68: o = kcat_mk(K_LD,  SEL_AA,  SEL_POS, SEL_POS);
         7'd69: o = kcat_mk(K_MSC, SEL_KA,  SEL_PA,  SEL_POS);
         7'd70: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_AA);
         7'd71: o = kcat_mk(K_LD,  SEL_PP,  SEL_POS, SEL_POS);
         7'd72: o = kcat_mk(K_MSC, SEL_KP,  SEL_PP,  SEL_POS);
         7'd73: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_PP);
         7'd74: o = kcat_mk(K_LD,  SEL_PV,  SEL_POS, SEL_POS);
         7'd75: o = kcat_mk(K_MSC, SEL_KP,  SEL_PV,  SEL_POS);
         7'd76: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_PV);
         7'd77: o = kcat_mk(K_LD,  SEL_PA,  SEL_POS, SEL_POS);
         7'd78: o = kcat_mk(K_MSC, SEL_KP,  SEL_PA,  SEL_POS);
         7'd79: o = kcat_mk(K_ST,  SEL_POS, SEL_POS, SEL_PA);
         default: o = kcat_mk(K_LD, SEL_POS, SEL_POS, SEL_POS);
      endcase
      return o;
   endfunction

endpackage

>>> hdl/kalman_const_accel_tracker_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Content
// req_     in         req_valid / req_stall   meas_x, meas_y, elapsed_us
// rsp_     out        rsp_valid / rsp_stall   estimates, was_missed, did_reset
// csr_     in         csr_valid / csr_ready   csr_index, csr_wdata
//
// A seen word runs the microprogramme on both axes; a missed word goes straight to output hand-off.
// The run time of a seen word is set by the shared bit-serial multiplier (32 steps) and the
// bit-serial divider (64 steps), which a per-axis microprogramme drives.
// Reset is synchronous; it restores registers, state and covariance at once.
// A new word is taken whilst the previous result still waits under rsp_stall.
module kalman_const_accel_tracker_unit import kcat_pkg::*; #(
   parameter int MISS_LIMIT = 5,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_meas_x,
   input  logic [31:0] req_meas_y,
   input  logic [19:0] req_elapsed_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_est_x,
   output logic [31:0] rsp_est_y,
   output logic [31:0] rsp_est_vx,
   output logic [31:0] rsp_est_vy,
   output logic [31:0] rsp_est_ax,
   output logic [31:0] rsp_est_ay,
   output logic        rsp_was_missed,
   output logic        rsp_did_reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [63:0] ONE_FX  = 64'(1) << FRAC_BITS;
   localparam logic [63:0] HALF_FX = 64'(1) << (FRAC_BITS - 1);
   localparam logic [3:0]  MISS_LIM = 4'(MISS_LIMIT);
   localparam word_type    ONE_W   = 32'(ONE_FX);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DT    = 3'd1;
   localparam logic [2:0] S_H     = 3'd2;
   localparam logic [2:0] S_FETCH = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_RND   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]  state_ff;
   logic [6:0]  pc_ff;
   logic        axis_ff;
   logic        skip_ff;
   logic [2:0]  miss_ff;
   logic [30:0] noise_pos_ff, noise_vel_ff, noise_acc_ff, noise_mea_ff;
   logic [27:0] start_x_ff, start_y_ff;

   word_type pos_ff [2];
   word_type vel_ff [2];
   word_type acc_ff [2];
   word_type pp_ff [2];
   word_type pv_ff [2];
   word_type pa_ff [2];
   word_type vv_ff [2];
   word_type va_ff [2];
   word_type aa_ff [2];
   word_type z_ff [2];
   word_type r1_ff, r2_ff, r3_ff, w2_ff, w3_ff, kp_ff, kv_ff, ka_ff, inn_ff, dt_ff, h_ff;
   accum_type accum_ff;
   accum_type rnd_ff;
   logic [33:0] den_ff;

   logic        rsp_valid_ff, was_missed_ff, did_reset_ff;
   logic        out_missed_ff, out_reset_ff;
   word_type    out_x_ff, out_y_ff, out_vx_ff, out_vy_ff, out_ax_ff, out_ay_ff;

   logic        accept, missed, skip_now, adv, out_free, wr_en;
   logic [19:0] us_cl;
   kcat_op_type op;
   word_type    opa, opb, gain, wr_val;
   accum_type   opa_ext;
   logic signed [32:0] opa_wide;
   logic [32:0] opa_abs;
   logic        mul_start, mul_done, div_start, div_done;
   word_type    mul_a, mul_b;
   logic [63:0] mul_prod, div_num, div_quot;
   logic [33:0] div_den;
   logic signed [63:0] rsum;
   accum_type   rnd_w;
   word_type    h_val;

   function automatic word_type pick(input logic [4:0] s);
      word_type v;
      case (s)
         SEL_POS: v = pos_ff[axis_ff];
         SEL_VEL: v = vel_ff[axis_ff];
         SEL_ACC: v = acc_ff[axis_ff];
         SEL_PP:  v = pp_ff[axis_ff];
         SEL_PV:  v = pv_ff[axis_ff];
         SEL_PA:  v = pa_ff[axis_ff];
         SEL_VV:  v = vv_ff[axis_ff];
         SEL_VA:  v = va_ff[axis_ff];
         SEL_AA:  v = aa_ff[axis_ff];
         SEL_R1:  v = r1_ff;
         SEL_R2:  v = r2_ff;
         SEL_R3:  v = r3_ff;
         SEL_W2:  v = w2_ff;
         SEL_W3:  v = w3_ff;
         SEL_KP:  v = kp_ff;
         SEL_KV:  v = kv_ff;
         SEL_KA:  v = ka_ff;
         SEL_INN: v = inn_ff;
         SEL_DT:  v = dt_ff;
         SEL_H:   v = h_ff;
         SEL_Z:   v = z_ff[axis_ff];
         SEL_QP:  v = {1'b0, noise_pos_ff};
         SEL_QV:  v = {1'b0, noise_vel_ff};
         SEL_QA:  v = {1'b0, noise_acc_ff};
         SEL_QR:  v = {1'b0, noise_mea_ff};
         default: v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      accept   = req_valid && !req_stall;
      missed   = req_meas_x[31] | req_meas_y[31];
      us_cl    = (req_elapsed_us < 20'd1000 || req_elapsed_us > 20'd100000) ?
                 20'd10000 : req_elapsed_us;
      op       = kcat_rom(pc_ff);
      opa      = pick(op.sa);
      opb      = pick(op.sb);
      opa_ext  = 50'(opa);
      opa_wide = 33'(opa);
      opa_abs  = opa[31] ? 33'(-opa_wide) : 33'(opa_wide);
      skip_now = skip_ff && (pc_ff >= PC_UPDATE);
      out_free = !rsp_valid_ff || !rsp_stall;

      mul_start = (state_ff == S_DT && div_done) ||
                  (state_ff == S_FETCH && !skip_now && (op.kind == K_MAC || op.kind == K_MSC));
      mul_a     = (state_ff == S_DT) ? div_quot[31:0] : opa;
      mul_b     = (state_ff == S_DT) ? div_quot[31:0] : opb;
      div_start = (state_ff == S_IDLE && accept && !missed) ||
                  (state_ff == S_FETCH && !skip_now && op.kind == K_DIV);
      div_num   = (state_ff == S_IDLE) ? (64'(us_cl) << FRAC_BITS) + 64'd500000 :
                  64'(opa_abs) << FRAC_BITS;
      div_den   = (state_ff == S_IDLE) ? 34'd1000000 : den_ff;

      rsum  = $signed(mul_prod) + $signed(HALF_FX);
      rnd_w = 50'(rsum >>> FRAC_BITS);
      h_val = 32'((mul_prod + ONE_FX) >> (FRAC_BITS + 1));

      if (!opa[31]) begin
         gain = (div_quot > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : div_quot[31:0];
      end else begin
         gain = (div_quot > 64'h80000000) ? 32'sh80000000 : -div_quot[31:0];
      end

      wr_en  = (state_ff == S_FETCH && !skip_now && op.kind == K_ST) ||
               (state_ff == S_DIV && div_done);
      wr_val = (state_ff == S_DIV) ? gain : kcat_sat32(accum_ff);

      adv = (state_ff == S_RND) || (state_ff == S_DIV && div_done) ||
            (state_ff == S_FETCH && (skip_now || op.kind == K_LD || op.kind == K_ADD ||
                                     op.kind == K_SUB || op.kind == K_ST ||
                                     op.kind == K_CHK));
   end

   kcat_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   kcat_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset || (state_ff == S_IDLE && accept && missed &&
                    ({1'b0, miss_ff} + 4'd1 > MISS_LIM))) begin
         pos_ff[0] <= {4'd0, start_x_ff};
         pos_ff[1] <= {4'd0, start_y_ff};
         for (int a = 0; a < 2; a++) begin
            vel_ff[a] <= '0;
            acc_ff[a] <= '0;
            pp_ff[a]  <= ONE_W;
            pv_ff[a]  <= '0;
            pa_ff[a]  <= '0;
            vv_ff[a]  <= ONE_W;
            va_ff[a]  <= '0;
            aa_ff[a]  <= ONE_W;
         end
         if (reset) begin
            pos_ff[0] <= '0;
            pos_ff[1] <= '0;
         end
      end else if (wr_en) begin
         case (op.dst)
            SEL_POS: pos_ff[axis_ff] <= wr_val;
            SEL_VEL: vel_ff[axis_ff] <= wr_val;
            SEL_ACC: acc_ff[axis_ff] <= wr_val;
            SEL_PP:  pp_ff[axis_ff]  <= wr_val;
            SEL_PV:  pv_ff[axis_ff]  <= wr_val;
            SEL_PA:  pa_ff[axis_ff]  <= wr_val;
            SEL_VV:  vv_ff[axis_ff]  <= wr_val;
            SEL_VA:  va_ff[axis_ff]  <= wr_val;
            SEL_AA:  aa_ff[axis_ff]  <= wr_val;
            SEL_R1:  r1_ff  <= wr_val;
            SEL_R2:  r2_ff  <= wr_val;
            SEL_R3:  r3_ff  <= wr_val;
            SEL_W2:  w2_ff  <= wr_val;
            SEL_W3:  w3_ff  <= wr_val;
            SEL_KP:  kp_ff  <= wr_val;
            SEL_KV:  kv_ff  <= wr_val;
            SEL_KA:  ka_ff  <= wr_val;
            SEL_INN: inn_ff <= wr_val;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pc_ff         <= '0;
         axis_ff       <= 1'b0;
         skip_ff       <= 1'b0;
         miss_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         noise_pos_ff  <= 31'(ONE_FX);
         noise_vel_ff  <= 31'(ONE_FX);
         noise_acc_ff  <= 31'(ONE_FX);
         noise_mea_ff  <= 31'(ONE_FX);
         start_x_ff    <= '0;
         start_y_ff    <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_NOISE_POS: noise_pos_ff <= csr_wdata[30:0];
               CSR_NOISE_VEL: noise_vel_ff <= csr_wdata[30:0];
               CSR_NOISE_ACC: noise_acc_ff <= csr_wdata[30:0];
               CSR_NOISE_MEA: noise_mea_ff <= csr_wdata[30:0];
               CSR_START_X:   start_x_ff   <= csr_wdata[27:0];
               CSR_START_Y:   start_y_ff   <= csr_wdata[27:0];
               default: ;
            endcase
         end

         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  z_ff[0]       <= req_meas_x;
                  z_ff[1]       <= req_meas_y;
                  was_missed_ff <= missed;
                  did_reset_ff  <= 1'b0;
                  if (missed) begin
                     if ({1'b0, miss_ff} + 4'd1 > MISS_LIM) begin
                        miss_ff      <= '0;
                        did_reset_ff <= 1'b1;
                     end else begin
                        miss_ff <= miss_ff + 3'd1;
                     end
                     state_ff <= S_DONE;
                  end else begin
                     miss_ff  <= '0;
                     state_ff <= S_DT;
                  end
               end
            end
            S_DT: begin
               if (div_done) begin
                  dt_ff    <= div_quot[31:0];
                  state_ff <= S_H;
               end
            end
            S_H: begin
               if (mul_done) begin
                  h_ff     <= h_val;
                  pc_ff    <= '0;
                  axis_ff  <= 1'b0;
                  skip_ff  <= 1'b0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               if (!skip_now) begin
                  case (op.kind)
                     K_LD:  accum_ff <= opa_ext;
                     K_ADD: accum_ff <= accum_ff + opa_ext;
                     K_SUB: accum_ff <= accum_ff - opa_ext;
                     K_CHK: begin
                        den_ff  <= accum_ff[33:0];
                        skip_ff <= (accum_ff <= 50'sd0);
                     end
                     K_MAC, K_MSC: state_ff <= S_MUL;
                     K_DIV: state_ff <= S_DIV;
                     default: ;
                  endcase
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  rnd_ff   <= rnd_w;
                  state_ff <= S_RND;
               end
            end
            S_RND: begin
               accum_ff <= (op.kind == K_MSC) ? accum_ff - rnd_ff : accum_ff + rnd_ff;
            end
            S_DIV: ;
            S_DONE: begin
               if (out_free) begin
                  out_x_ff      <= pos_ff[0];
                  out_y_ff      <= pos_ff[1];
                  out_vx_ff     <= vel_ff[0];
                  out_vy_ff     <= vel_ff[1];
                  out_ax_ff     <= acc_ff[0];
                  out_ay_ff     <= acc_ff[1];
                  out_missed_ff <= was_missed_ff;
                  out_reset_ff  <= did_reset_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         if (adv) begin
            if (pc_ff == PC_LAST) begin
               if (!axis_ff) begin
                  axis_ff  <= 1'b1;
                  pc_ff    <= '0;
                  skip_ff  <= 1'b0;
                  state_ff <= S_FETCH;
               end else begin
                  state_ff <= S_DONE;
               end
            end else begin
               pc_ff    <= pc_ff + 7'd1;
               state_ff <= S_FETCH;
            end
         end
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_est_x      = out_x_ff;
   assign rsp_est_y      = out_y_ff;
   assign rsp_est_vx     = out_vx_ff;
   assign rsp_est_vy     = out_vy_ff;
   assign rsp_est_ax     = out_ax_ff;
   assign rsp_est_ay     = out_ay_ff;
   assign rsp_was_missed = out_missed_ff;
   assign rsp_did_reset  = out_reset_ff;

endmodule

>>> hdl/kcat_mul.sv
`timescale 1ns / 1ps
module kcat_mul import kcat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  word_type    op_a,
   input  word_type    op_b,
   output logic        done,
   output logic [63:0] product
);

   logic        run_ff;
   logic        done_ff;
   logic [4:0]  count_ff;
   word_type    mcand_ff;
   logic signed [33:0] ph_ff;
   logic [31:0] pl_ff;
   logic signed [33:0] addend;
   logic signed [33:0] sum;

   // The sign bit of the multiplier carries negative weight.
   always_comb begin
      if (!pl_ff[0]) begin
         addend = '0;
      end else if (count_ff == 5'd31) begin
         addend = -34'(mcand_ff);
      end else begin
         addend = 34'(mcand_ff);
      end
      sum = ph_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= '0;
            mcand_ff <= op_a;
            ph_ff    <= '0;
            pl_ff    <= op_b;
         end else if (run_ff) begin
            ph_ff    <= {sum[33], sum[33:1]};
            pl_ff    <= {sum[0], pl_ff[31:1]};
            count_ff <= count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = {ph_ff[31:0], pl_ff};

endmodule

>>> hdl/kcat_div.sv
`timescale 1ns / 1ps
module kcat_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] numer,
   input  logic [33:0] denom,
   output logic        done,
   output logic [63:0] quot
);

   logic        run_ff;
   logic        done_ff;
   logic [5:0]  count_ff;
   logic [33:0] den_ff;
   logic [34:0] rem_ff;
   logic [63:0] q_ff;
   logic [34:0] trial;
   logic        ge;

   always_comb begin
      trial = {rem_ff[33:0], q_ff[63]};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff   <= 1'b1;
            count_ff <= '0;
            den_ff   <= denom;
            rem_ff   <= '0;
            q_ff     <= numer;
         end else if (run_ff) begin
            rem_ff   <= ge ? trial - {1'b0, den_ff} : trial;
            q_ff     <= {q_ff[62:0], ge};
            count_ff <= count_ff + 6'd1;
            if (count_ff == 6'd63) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
